// ===== rtl/core/cqsd_pkg.sv =====
package cqsd_pkg;

  localparam int WORD_W        = 32;
  localparam int MAX_SLOTS_DEF = 16;
  localparam int CNT_W         = 5;
  localparam int POS_W         = 4;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 5'd16;

  typedef enum logic [2:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_DELETE = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ===== rtl/core/cqsd_ram.sv =====
module cqsd_ram #(
  parameter int WIDTH = cqsd_pkg::WORD_W,
  parameter int DEPTH = cqsd_pkg::MAX_SLOTS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cqsd_ctrl.sv =====
module cqsd_ctrl #(
  parameter int MAX_SLOTS = cqsd_pkg::MAX_SLOTS_DEF,
  localparam int PW       = $clog2(MAX_SLOTS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic [PW-1:0]                     ring_last,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        req_type,
  input  logic signed [cqsd_pkg::WORD_W-1:0] value,
  output logic                              ram_we,
  output logic [PW-1:0]                     ram_waddr,
  output logic [cqsd_pkg::WORD_W-1:0]       ram_wdata,
  output logic [PW-1:0]                     ram_raddr,
  input  logic [cqsd_pkg::WORD_W-1:0]       ram_rdata,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [cqsd_pkg::WORD_W-1:0] data,
  output logic [cqsd_pkg::POS_W-1:0]        position
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PEEK  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_SHIFT = 4'b1000
  } state_t;

  state_t                        state;
  logic [PW-1:0]                 head;
  logic [PW-1:0]                 tail;
  logic [PW-1:0]                 scan_ptr;
  logic [PW-1:0]                 cmp_ptr;
  logic                          cmp_vld;
  logic [PW-1:0]                 wr_ptr;
  logic [PW-1:0]                 src_ptr;
  logic                          sh_vld;
  logic                          is_del;
  logic [cqsd_pkg::WORD_W-1:0]   key;
  logic [PW-1:0]                 pos_ptr;
  cqsd_pkg::status_t             status_r;
  logic [PW+cqsd_pkg::POS_W-1:0] pos_ext;

  logic [PW-1:0] head_adv;
  logic [PW-1:0] tail_adv;
  logic [PW-1:0] tail_dec;
  logic          empty;
  logic          full;
  logic          accept;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [PW-1:0] last);
    adv = (p == last) ? '0 : PW'(p + 1'b1);
  endfunction

  assign head_adv = adv(head, ring_last);
  assign tail_adv = adv(tail, ring_last);
  assign tail_dec = (tail == '0) ? ring_last : PW'(tail - 1'b1);
  assign empty    = (head == tail);
  assign full     = (tail_adv == head);
  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);

  // read port: head in idle (peek / first scan slot), walk pointer otherwise
  always_comb begin
    case (state)
      ST_SCAN:  ram_raddr = scan_ptr;
      ST_SHIFT: ram_raddr = src_ptr;
      default:  ram_raddr = head;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = value;
    if (accept && (req_type == cqsd_pkg::REQ_ENQ) && !full) begin
      ram_we = 1'b1;
    end else if ((state == ST_SHIFT) && sh_vld) begin
      ram_we    = 1'b1;
      ram_waddr = wr_ptr;
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (clear) begin
            head <= '0;
            tail <= '0;
          end else if (start) begin
            data    <= '0;
            pos_ptr <= '0;
            case (req_type)
              cqsd_pkg::REQ_ENQ: begin
                done <= 1'b1;
                if (full) begin
                  status_r <= cqsd_pkg::STAT_FULL;
                end else begin
                  status_r <= cqsd_pkg::STAT_OK;
                  tail     <= tail_adv;
                end
              end
              cqsd_pkg::REQ_DEQ: begin
                done <= 1'b1;
                if (empty) begin
                  status_r <= cqsd_pkg::STAT_EMPTY;
                end else begin
                  status_r <= cqsd_pkg::STAT_OK;
                  head     <= head_adv;
                end
              end
              cqsd_pkg::REQ_PEEK: begin
                if (empty) begin
                  done     <= 1'b1;
                  status_r <= cqsd_pkg::STAT_EMPTY;
                end else begin
                  state <= ST_PEEK;
                end
              end
              cqsd_pkg::REQ_SEARCH, cqsd_pkg::REQ_DELETE: begin
                key      <= value;
                is_del   <= (req_type == cqsd_pkg::REQ_DELETE);
                cmp_ptr  <= head;
                cmp_vld  <= !empty;
                scan_ptr <= head_adv;
                state    <= ST_SCAN;
              end
              default: begin
                done     <= 1'b1;
                status_r <= cqsd_pkg::STAT_OK;
              end
            endcase
          end
        end
        ST_PEEK: begin
          done     <= 1'b1;
          status_r <= cqsd_pkg::STAT_OK;
          data     <= ram_rdata;
          state    <= ST_IDLE;
        end
        ST_SCAN: begin
          // rdata holds the word at cmp_ptr; scan_ptr is read in this cycle
          if (!cmp_vld) begin
            done     <= 1'b1;
            status_r <= cqsd_pkg::STAT_NOT_FOUND;
            state    <= ST_IDLE;
          end else if (ram_rdata == key) begin
            pos_ptr  <= cmp_ptr;
            status_r <= cqsd_pkg::STAT_OK;
            if (is_del) begin
              wr_ptr  <= cmp_ptr;
              src_ptr <= adv(scan_ptr, ring_last);
              sh_vld  <= (scan_ptr != tail);
              state   <= ST_SHIFT;
            end else begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          end else begin
            cmp_ptr  <= scan_ptr;
            cmp_vld  <= (scan_ptr != tail);
            scan_ptr <= adv(scan_ptr, ring_last);
          end
        end
        ST_SHIFT: begin
          // each cycle moves the word read last cycle one slot toward head
          if (sh_vld) begin
            wr_ptr  <= adv(wr_ptr, ring_last);
            src_ptr <= adv(src_ptr, ring_last);
            sh_vld  <= (src_ptr != tail);
          end else begin
            tail  <= tail_dec;
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign pos_ext  = {{cqsd_pkg::POS_W{1'b0}}, pos_ptr};
  assign position = pos_ext[cqsd_pkg::POS_W-1:0];
  assign status   = status_r;

endmodule

// ===== rtl/core/circular_queue_search_delete_unit.sv =====
// Ring FIFO of 32-bit words with search and delete-by-value, one request at a time.
// Enqueue, dequeue, unknown requests and a peek on an empty queue: result strobe in the cycle after start.
// Peek reads the head slot from the ST_PEEK state. Search: one slot compared per cycle.
// Delete: each occupied slot is compared or moved once.
// busy stays high until the done cycle; the next start is taken in the done cycle.
// Sync reset empties the queue and sets slot_count to 16; slot contents are not cleared.
module circular_queue_search_delete_unit #(
  parameter int MAX_SLOTS = cqsd_pkg::MAX_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         req_type,
  input  logic signed [cqsd_pkg::WORD_W-1:0] value,
  input  logic                               cfg_wr_en,
  input  logic [cqsd_pkg::CNT_W-1:0]         cfg_wr_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [cqsd_pkg::WORD_W-1:0] data,
  output logic [cqsd_pkg::POS_W-1:0]         position
);

  localparam int PW  = $clog2(MAX_SLOTS);
  localparam int NW0 = $clog2(MAX_SLOTS + 1);
  localparam int CW  = (NW0 > cqsd_pkg::CNT_W) ? NW0 : cqsd_pkg::CNT_W;

  logic [cqsd_pkg::CNT_W-1:0]  slot_count;
  logic [CW-1:0]               cnt_ext;
  logic [CW-1:0]               ring_n;
  logic [PW-1:0]               ring_last;

  logic                        ram_we;
  logic [PW-1:0]               ram_waddr;
  logic [cqsd_pkg::WORD_W-1:0] ram_wdata;
  logic [PW-1:0]               ram_raddr;
  logic [cqsd_pkg::WORD_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= cqsd_pkg::SLOT_COUNT_RST;
    end else if (cfg_wr_en) begin
      slot_count <= cfg_wr_data;
    end
  end

  // effective ring size, clamped to 2..MAX_SLOTS
  assign cnt_ext = CW'(slot_count);
  always_comb begin
    if (cnt_ext < CW'(2)) begin
      ring_n = CW'(2);
    end else if (cnt_ext > CW'(MAX_SLOTS)) begin
      ring_n = CW'(MAX_SLOTS);
    end else begin
      ring_n = cnt_ext;
    end
  end
  assign ring_last = PW'(ring_n - 1'b1);

  cqsd_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_wr_en),
    .ring_last (ring_last),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .value     (value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .status    (status),
    .data      (data),
    .position  (position)
  );

  cqsd_ram #(
    .WIDTH (cqsd_pkg::WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== bench/tb_circular_queue_search_delete_unit.sv =====
`timescale 1ns / 100ps

module tb_circular_queue_search_delete_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PER_PHASE = 120;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    cqsd_pkg::status_t st;
    logic [31:0]       dat;
    logic [3:0]        pos;
  } result_t;

  typedef struct {
    bit                is_cfg;
    logic [2:0]        req;
    logic [31:0]       word;
    bit                fixed;
    cqsd_pkg::status_t st;
    logic [31:0]       dat;
    logic [3:0]        pos;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  req_type = '0;
  logic [31:0] value = '0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] data;
  logic [3:0]  position;

  // mirror of the queue
  logic [31:0] slot_mirror [cqsd_pkg::MAX_SLOTS_DEF];
  int          head_ptr;
  int          tail_ptr;
  logic [4:0]  slot_cfg;

  result_t     expected_results [$];
  int          cycle_count;
  int          mismatches;
  int          requests_sent;
  int          results_checked;
  int          cfg_writes;
  int          full_seen;
  int          empty_seen;
  int          miss_seen;
  int          deletes_done;

  circular_queue_search_delete_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .value      (value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done       (done),
    .status     (status),
    .data       (data),
    .position   (position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ring_n();
    if (slot_cfg < 5'd2) return 2;
    if (slot_cfg > 5'(cqsd_pkg::MAX_SLOTS_DEF)) return cqsd_pkg::MAX_SLOTS_DEF;
    return int'(slot_cfg);
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= ring_n()) ? 0 : p + 1;
  endfunction

  function automatic int fill_level();
    return (tail_ptr - head_ptr + ring_n()) % ring_n();
  endfunction

  // first match walking front to rear
  function automatic bit find_slot(logic [31:0] word, output int slot);
    int i;
    int g;
    i = head_ptr;
    g = 0;
    slot = 0;
    while (i != tail_ptr && g < ring_n()) begin
      if (slot_mirror[i] == word) begin
        slot = i;
        return 1'b1;
      end
      i = next_slot(i);
      g++;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(logic [2:0] req, logic [31:0] word);
    result_t r;
    int      hit_slot;
    int      cur;
    int      nxt;
    int      g;
    r = '{st: cqsd_pkg::STAT_OK, dat: '0, pos: '0};
    case (req)
      cqsd_pkg::REQ_ENQ: begin
        if (next_slot(tail_ptr) == head_ptr) begin
          r.st = cqsd_pkg::STAT_FULL;
        end else begin
          slot_mirror[tail_ptr] = word;
          tail_ptr = next_slot(tail_ptr);
        end
      end
      cqsd_pkg::REQ_DEQ: begin
        if (head_ptr == tail_ptr) r.st = cqsd_pkg::STAT_EMPTY;
        else head_ptr = next_slot(head_ptr);
      end
      cqsd_pkg::REQ_PEEK: begin
        if (head_ptr == tail_ptr) r.st = cqsd_pkg::STAT_EMPTY;
        else r.dat = slot_mirror[head_ptr];
      end
      cqsd_pkg::REQ_SEARCH: begin
        if (find_slot(word, hit_slot)) r.pos = 4'(hit_slot);
        else r.st = cqsd_pkg::STAT_NOT_FOUND;
      end
      cqsd_pkg::REQ_DELETE: begin
        if (!find_slot(word, hit_slot)) begin
          r.st = cqsd_pkg::STAT_NOT_FOUND;
        end else begin
          r.pos = 4'(hit_slot);
          cur = hit_slot;
          nxt = next_slot(hit_slot);
          g = 0;
          // close the gap: later words move one slot toward front
          while (nxt != tail_ptr && g < ring_n()) begin
            slot_mirror[cur] = slot_mirror[nxt];
            cur = nxt;
            nxt = next_slot(nxt);
            g++;
          end
          tail_ptr = (tail_ptr == 0) ? ring_n() - 1 : tail_ptr - 1;
          deletes_done++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [2:0] req, logic [31:0] word, bit fixed,
                              result_t typed);
    result_t r;
    start    <= 1'b1;
    req_type <= req;
    value    <= word;
    do @(posedge clk); while (busy);
    r = predict_result(req, word);
    expected_results.push_back(fixed ? typed : r);
    requests_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [4:0] cnt);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slot_cfg = cnt;
    head_ptr = 0;
    tail_ptr = 0;
    cfg_writes++;
  endtask

  task automatic idle_gap(int pct);
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // extremes and a few small values so duplicates show up
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_request(int enq_weight);
    int          r;
    logic [2:0]  req;
    logic [31:0] word;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end else if (r < 3 + enq_weight) begin
      req = cqsd_pkg::REQ_ENQ;
    end else begin
      case ($urandom_range(0, 3))
        0: req = cqsd_pkg::REQ_DEQ;
        1: req = cqsd_pkg::REQ_PEEK;
        2: req = cqsd_pkg::REQ_SEARCH;
        default: req = cqsd_pkg::REQ_DELETE;
      endcase
    end
    word = pick_word();
    if ((req == cqsd_pkg::REQ_SEARCH || req == cqsd_pkg::REQ_DELETE) && fill_level() > 0 &&
        $urandom_range(0, 99) < 65)
      word = slot_mirror[(head_ptr + $urandom_range(0, fill_level() - 1)) % ring_n()];
    else if (req != cqsd_pkg::REQ_ENQ && req != cqsd_pkg::REQ_SEARCH &&
             req != cqsd_pkg::REQ_DELETE)
      word = $urandom;
    send_request(req, word, 1'b0, '0);
  endtask

  dir_row_t directed_rows [24] = '{
    '{0, cqsd_pkg::REQ_PEEK,   32'h0,         1, cqsd_pkg::STAT_EMPTY, 32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_DEQ,    32'h0,         1, cqsd_pkg::STAT_EMPTY, 32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_SEARCH, 32'h5,         1, cqsd_pkg::STAT_NOT_FOUND, 32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_DELETE, 32'h5,         1, cqsd_pkg::STAT_NOT_FOUND, 32'h0, 4'd0},
    '{0, REQ_UNUSED_LO,        32'h5a5a_5a5a, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'h7fff_ffff, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'h8000_0000, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'hffff_ffff, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'h0,         1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_PEEK,   32'h0,         1, cqsd_pkg::STAT_OK,    32'h7fff_ffff, 4'd0},
    '{0, cqsd_pkg::REQ_SEARCH, 32'hffff_ffff, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd2},
    '{0, cqsd_pkg::REQ_DELETE, 32'h8000_0000, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd1},
    '{0, cqsd_pkg::REQ_SEARCH, 32'h0,         1, cqsd_pkg::STAT_OK,    32'h0, 4'd2},
    '{0, cqsd_pkg::REQ_SEARCH, 32'd12345,     1, cqsd_pkg::STAT_NOT_FOUND, 32'h0, 4'd0},
    '{0, REQ_UNUSED_HI,        32'hffff_ffff, 1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_DEQ,    32'h0,         0, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_PEEK,   32'h0,         1, cqsd_pkg::STAT_OK,    32'hffff_ffff, 4'd0},
    '{0, cqsd_pkg::REQ_DELETE, 32'h0,         0, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_DEQ,    32'h0,         0, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_DEQ,    32'h0,         1, cqsd_pkg::STAT_EMPTY, 32'h0, 4'd0},
    // count below the minimum: ring of two, one word fits
    '{1, cqsd_pkg::REQ_ENQ,    32'd1,         0, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'd11,        1, cqsd_pkg::STAT_OK,    32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_ENQ,    32'd22,        1, cqsd_pkg::STAT_FULL,  32'h0, 4'd0},
    '{0, cqsd_pkg::REQ_SEARCH, 32'd11,        0, cqsd_pkg::STAT_OK,    32'h0, 4'd0}
  };

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d data %0h position %0d",
               status, data, position);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.st == cqsd_pkg::STAT_FULL) full_seen++;
        if (want.st == cqsd_pkg::STAT_EMPTY) empty_seen++;
        if (want.st == cqsd_pkg::STAT_NOT_FOUND) miss_seen++;
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatches++;
        end
        if (data !== want.dat) begin
          $error("data: expected %0h, got %0h", want.dat, data);
          mismatches++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int slot_plan [11];
    int idle_plan [4];
    int enq_weight;
    slot_plan = '{16, 2, 0, 5, 31, 3, 1, 17, 9, 16, 0};
    idle_plan = '{0, 54, 0, 32};
    slot_cfg = cqsd_pkg::SLOT_COUNT_RST;
    head_ptr = 0;
    tail_ptr = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg)
        write_slot_count(directed_rows[k].word[4:0]);
      else
        send_request(directed_rows[k].req, directed_rows[k].word, directed_rows[k].fixed,
                     '{st: directed_rows[k].st, dat: directed_rows[k].dat,
                       pos: directed_rows[k].pos});
    end

    slot_plan[10] = $urandom_range(0, 31);
    foreach (slot_plan[p]) begin
      write_slot_count(5'(slot_plan[p]));
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        // alternate filling and draining stretches
        enq_weight = ((i / 30) % 2 == 0) ? 45 : 20;
        send_random_request(enq_weight);
        if ($urandom_range(0, 63) == 0)
          wait_drained();
        else
          idle_gap(idle_plan[p % 4]);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("%0d requests over %0d ring-size writes (clamped sizes included), %0d words checked",
             requests_sent, cfg_writes, results_checked);
    $display("refusals seen: %0d full, %0d empty, %0d not found; %0d deletes with shift",
             full_seen, empty_seen, miss_seen, deletes_done);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cqsd_pkg.sv
rtl/core/cqsd_ram.sv
rtl/core/cqsd_ctrl.sv
rtl/core/circular_queue_search_delete_unit.sv
bench/tb_circular_queue_search_delete_unit.sv
